// ===== src/lzssd_pkg.sv =====
// Shared types and constants for the LZSS stream decompressor.
package lzssd_pkg;

   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;
   localparam int LEN_W = 5;
   localparam int OUT_LEN_W = 21;
   localparam int CAP_W = 21;

   localparam logic [3:0] ITEMS_PER_FLAG = 4'd8;
   localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;
   localparam logic [CAP_W-1:0] CAP_RESET = 21'd1048576;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_STATUS = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic has_data;
      logic is_match;
      logic has_status;
      logic status_err;
      logic [7:0] data;
      logic [HIST_AW-1:0] offset;
      logic [LEN_W-1:0] len;
      logic [HIST_AW-1:0] addr;
      logic [OUT_LEN_W-1:0] length;
   } cmd_type;

endpackage

// ===== src/lzssd_front.sv =====
// Parser that turns compressed bytes into literal, match and status commands.
module lzssd_front #(
   parameter int COUNT_BITS = 21
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_in_byte,
   input  logic req_block_end,
   input  logic csr_wr_en,
   input  logic [lzssd_pkg::CAP_W-1:0] csr_wr_data,
   output logic push,
   output lzssd_pkg::cmd_type push_cmd,
   input  logic queue_full
);
   import lzssd_pkg::*;

   localparam int EXT_W = (COUNT_BITS > OUT_LEN_W) ? COUNT_BITS : OUT_LEN_W;
   localparam int CMP_W = EXT_W + 1;
   localparam logic [CMP_W-1:0] MAX_W = CMP_W'({COUNT_BITS{1'b1}});
   localparam logic [CMP_W-1:0] CAP_RST_W =
      (CMP_W'(CAP_RESET) > MAX_W) ? MAX_W : CMP_W'(CAP_RESET);

   logic [COUNT_BITS-1:0] pc_ff, pc_in;
   logic [7:0] flags_ff, flags_in;
   logic [3:0] idx_ff, idx_in;
   logic exp_low_ff, exp_low_in;
   logic [7:0] thigh_ff, thigh_in;
   logic err_ff, err_in;
   logic [COUNT_BITS-1:0] cap_ff, cap_in;

   logic accept;
   logic [CMP_W-1:0] pc_c, cap_c, offset_c, len_c, wd_c, cap_sat;
   logic [HIST_AW-1:0] offset;
   logic [LEN_W-1:0] len;
   logic [3:0] next_idx;
   logic match_bad, lit_bad;
   logic [EXT_W-1:0] pc_wide;
   cmd_type cmd;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;

   assign offset = {thigh_ff, req_in_byte[7:4]};
   assign len = LEN_W'(req_in_byte[3:0]) + LEN_BIAS;
   assign pc_c = CMP_W'(pc_ff);
   assign cap_c = CMP_W'(cap_ff);
   assign offset_c = CMP_W'(offset);
   assign len_c = CMP_W'(len);
   assign match_bad = (offset == '0) || (offset_c > pc_c) || ((pc_c + len_c) > cap_c);
   assign lit_bad = (pc_c >= cap_c);
   assign next_idx = (idx_ff + 4'd1 >= ITEMS_PER_FLAG) ? ITEMS_PER_FLAG : idx_ff + 4'd1;

   assign wd_c = CMP_W'(csr_wr_data);
   assign cap_sat = (wd_c > MAX_W) ? MAX_W : wd_c;
   assign cap_in = csr_wr_en ? cap_sat[COUNT_BITS-1:0] : cap_ff;

   always_comb begin
      pc_in = pc_ff;
      flags_in = flags_ff;
      idx_in = idx_ff;
      exp_low_in = exp_low_ff;
      thigh_in = thigh_ff;
      err_in = err_ff;
      cmd = '0;
      pc_wide = '0;
      if (!err_ff) begin
         priority if (idx_ff >= ITEMS_PER_FLAG) begin
            flags_in = req_in_byte;
            idx_in = '0;
         end else if (exp_low_ff) begin
            exp_low_in = 1'b0;
            if (match_bad) begin
               err_in = 1'b1;
            end else begin
               cmd.has_data = 1'b1;
               cmd.is_match = 1'b1;
               cmd.offset = offset;
               cmd.len = len;
               cmd.addr = pc_ff[HIST_AW-1:0];
               pc_in = pc_ff + COUNT_BITS'(len);
               idx_in = next_idx;
            end
         end else if (flags_ff[idx_ff[2:0]]) begin
            if (lit_bad) begin
               err_in = 1'b1;
            end else begin
               cmd.has_data = 1'b1;
               cmd.data = req_in_byte;
               cmd.addr = pc_ff[HIST_AW-1:0];
               pc_in = pc_ff + COUNT_BITS'(1);
               idx_in = next_idx;
            end
         end else begin
            thigh_in = req_in_byte;
            exp_low_in = 1'b1;
         end
      end
      if (req_block_end) begin
         pc_wide = EXT_W'(pc_in);
         cmd.has_status = 1'b1;
         cmd.status_err = err_in || exp_low_in;
         cmd.length = (err_in || exp_low_in) ? '0 : pc_wide[OUT_LEN_W-1:0];
         pc_in = '0;
         flags_in = '0;
         idx_in = ITEMS_PER_FLAG;
         exp_low_in = 1'b0;
         thigh_in = '0;
         err_in = 1'b0;
      end
   end

   assign push = accept && (cmd.has_data || cmd.has_status);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         flags_ff <= '0;
         idx_ff <= ITEMS_PER_FLAG;
         exp_low_ff <= 1'b0;
         thigh_ff <= '0;
         err_ff <= 1'b0;
         cap_ff <= CAP_RST_W[COUNT_BITS-1:0];
      end else begin
         cap_ff <= cap_in;
         if (accept) begin
            pc_ff <= pc_in;
            flags_ff <= flags_in;
            idx_ff <= idx_in;
            exp_low_ff <= exp_low_in;
            thigh_ff <= thigh_in;
            err_ff <= err_in;
         end
      end
   end

   // An error always leaves the parser between tokens.
   assert property (@(posedge clock) disable iff (reset) err_ff |-> !exp_low_ff)
      else $error("token pending while in error");
   // A token low byte is only expected inside a flag group.
   assert property (@(posedge clock) disable iff (reset)
      exp_low_ff |-> (idx_ff < ITEMS_PER_FLAG))
      else $error("token pending outside a flag group");

endmodule

// ===== src/lzssd_queue.sv =====
// Small command queue between the parser and the copy engine.
module lzssd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  lzssd_pkg::cmd_type push_cmd,
   output logic full,
   input  logic pop,
   output lzssd_pkg::cmd_type pop_cmd,
   output logic empty
);
   import lzssd_pkg::*;

   cmd_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0] count_ff, count_in;

   assign full = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
   assign count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) (push |-> !full) and (pop |-> !empty))
      else $error("queue overrun or underrun");

endmodule

// ===== src/lzssd_back.sv =====
// Copy engine: emits literal and match bytes, keeps the history, emits status.
module lzssd_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  lzssd_pkg::cmd_type q_cmd,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic rsp_status,
   output logic [lzssd_pkg::OUT_LEN_W-1:0] rsp_out_length,
   output logic rsp_last
);
   import lzssd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LIT  = 5'b00010,
      S_READ = 5'b00100,
      S_COPY = 5'b01000,
      S_STAT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [HIST_AW-1:0] cur_addr_ff, cur_addr_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [7:0] hist_mem [HIST_DEPTH];
   logic [7:0] rd_data_ff;
   logic [HIST_AW-1:0] rd_addr;
   logic we;
   logic [7:0] wdata;

   logic slot_free, emit;
   logic e_kind, e_status, e_last;
   logic [7:0] e_byte;
   logic [OUT_LEN_W-1:0] e_length;

   logic rsp_valid_ff, rsp_kind_ff, rsp_status_ff, rsp_last_ff;
   logic [7:0] rsp_data_ff;
   logic [OUT_LEN_W-1:0] rsp_length_ff;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rd_addr = cur_addr_ff - cmd_ff.offset;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      cur_addr_in = cur_addr_ff;
      rem_in = rem_ff;
      pop = 1'b0;
      we = 1'b0;
      wdata = '0;
      emit = 1'b0;
      e_kind = KIND_DATA;
      e_byte = '0;
      e_status = STATUS_OK;
      e_length = '0;
      e_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               cmd_in = q_cmd;
               cur_addr_in = q_cmd.addr;
               rem_in = q_cmd.len;
               if (!q_cmd.has_data) begin
                  state_in = S_STAT;
               end else if (q_cmd.is_match) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_LIT;
               end
            end
         end
         S_LIT: begin
            if (slot_free) begin
               emit = 1'b1;
               e_byte = cmd_ff.data;
               e_last = !cmd_ff.has_status;
               we = 1'b1;
               wdata = cmd_ff.data;
               state_in = cmd_ff.has_status ? S_STAT : S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_COPY;
         end
         S_COPY: begin
            if (slot_free) begin
               emit = 1'b1;
               e_byte = rd_data_ff;
               we = 1'b1;
               wdata = rd_data_ff;
               cur_addr_in = cur_addr_ff + HIST_AW'(1);
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  e_last = !cmd_ff.has_status;
                  state_in = cmd_ff.has_status ? S_STAT : S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_STAT: begin
            if (slot_free) begin
               emit = 1'b1;
               e_kind = KIND_STATUS;
               e_status = cmd_ff.status_err ? STATUS_ERR : STATUS_OK;
               e_length = cmd_ff.length;
               e_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cur_addr_ff <= cur_addr_in;
      rem_ff <= rem_in;
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_data_ff <= e_byte;
         rsp_status_ff <= e_status;
         rsp_length_ff <= e_length;
         rsp_last_ff <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[cur_addr_ff] <= wdata;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_out_length = rsp_length_ff;
   assign rsp_last = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset) (state_ff == S_COPY) |-> (rem_ff != '0))
      else $error("copy with no bytes left");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_STATUS) |-> rsp_last_ff)
      else $error("status result not marked last");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_STATUS && rsp_status_ff == STATUS_ERR)
      |-> (rsp_length_ff == '0))
      else $error("error status with nonzero length");

endmodule

// ===== src/lzss_stream_decompressor_top.sv =====
// Top level of the LZSS stream decompressor.
// Compressed bytes enter one per transfer and are parsed at up to one per cycle, while
// the queue is not full, into a four-entry command queue; the copy engine behind it sets
// the throughput. It emits a literal from a literal state, and for a match token of 3 to 18
// bytes reads each byte from the 4096-byte history in a read state, then emits it and
// writes it back in a copy state. An end-of-block status is emitted from a status state,
// after the last byte or on its own. Flag bytes and token high bytes produce no result.
// Results leave through a register, and the copy engine waits whenever that register
// holds a result stalled by rsp_stall.
module lzss_stream_decompressor_top #(
   parameter int COUNT_BITS = 21
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_in_byte,
   input  logic req_block_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic rsp_status,
   output logic [20:0] rsp_out_length,
   output logic rsp_last,
   input  logic csr_wr_en,
   input  logic [20:0] csr_wr_data
);
   import lzssd_pkg::*;

   logic push, pop, q_full, q_empty;
   cmd_type push_cmd, pop_cmd;

   lzssd_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_block_end(req_block_end),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push(push),
      .push_cmd(push_cmd),
      .queue_full(q_full)
   );

   lzssd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .full(q_full),
      .pop(pop),
      .pop_cmd(pop_cmd),
      .empty(q_empty)
   );

   lzssd_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_cmd(pop_cmd),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_status(rsp_status),
      .rsp_out_length(rsp_out_length),
      .rsp_last(rsp_last)
   );

endmodule
